@@ rtl/qom_pkg.sv @@
// Shared types and codes for the quote order matcher.
package qom_pkg;

	localparam int PRICE_W = 24;
	localparam int QTY_W   = 20;
	localparam int COST_W  = 44;
	localparam int DQ_W    = 24;
	localparam int DC_W    = 56;
	localparam int SYM_W   = 4;
	localparam int EXCH_W  = 2;
	localparam int IDX_W   = 5;
	localparam int CNT_W   = 6;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_FILL = 2'd1;
	localparam logic [1:0] KIND_SUM  = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUOTE = 1'b1;

	localparam logic SIDE_BID = 1'b0;

	typedef struct packed {
		logic               side;
		logic [SYM_W-1:0]   sym;
		logic [PRICE_W-1:0] limit;
		logic [QTY_W-1:0]   qty;
		logic [QTY_W-1:0]   filled;
		logic [COST_W-1:0]  cost;
	} order_t;

	typedef struct packed {
		logic               side;
		logic [SYM_W-1:0]   sym;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   rem;
	} quote_t;

	typedef struct packed {
		logic              hit;
		logic              full;
		logic [QTY_W-1:0]  deal;
	} fill_t;

endpackage

@@ rtl/qom_cell.sv @@
// One order slot of the circulating order chain.
module qom_cell
	import qom_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  logic   load_en,
	input  order_t load_order,
	input  order_t from_next,
	output order_t order
);

	order_t order_q;

	// payload only: no reset needed
	always_ff @(posedge clk) begin
		if (load_en) begin
			order_q <= load_order;
		end else if (shift) begin
			order_q <= from_next;
		end
	end

	assign order = order_q;

endmodule

@@ rtl/qom_match.sv @@
// Match unit at the head of the chain: prices one order against the quote.
module qom_match
	import qom_pkg::*;
(
	input  logic   enable,
	input  order_t head,
	input  quote_t quote,
	output order_t updated,
	output fill_t  fill
);

	logic             price_ok;
	logic [QTY_W-1:0] open_qty;

	always_comb begin
		price_ok = (quote.side == SIDE_BID) ? (quote.price >= head.limit)
		                                    : (quote.price <= head.limit);
		open_qty = head.qty - head.filled;
		fill.hit = enable && (head.sym == quote.sym) && (head.side != quote.side)
		           && price_ok && (head.filled < head.qty);
		fill.full = quote.rem <= open_qty;
		fill.deal = fill.full ? quote.rem : open_qty;
		updated = head;
		if (fill.hit) begin
			updated.filled = head.filled + fill.deal;
		end
	end

endmodule

@@ rtl/quote_order_matcher_core.sv @@
// Top level: order chain, match unit, deal totals memory and result register.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------------
//  command   | start, busy (accept: start & !busy) | command side symbol_id exchange_id
//            |                            | price_ticks amount
//  result    | result_valid (one cycle)   | kind status order_index fill_size ...
//
// A load's acknowledge appears the cycle after acceptance.
// A quote makes the order chain and the cost stage take one full turn, one
// slot per cycle past the match unit, plus the deal-total read, settle and
// summary states. A fill result is registered from the cost stage, once its
// cost has been added there, after its order passes the match unit.
// Reset clears the order count, control state and the deal-total valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module quote_order_matcher_core
	import qom_pkg::*;
#(
	parameter int MAX_ORDERS    = 32,
	parameter int NUM_SYMBOLS   = 16,
	parameter int NUM_EXCHANGES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic                side,
	input  logic [SYM_W-1:0]    symbol_id,
	input  logic [EXCH_W-1:0]   exchange_id,
	input  logic [PRICE_W-1:0]  price_ticks,
	input  logic [QTY_W-1:0]    amount,
	output logic                result_valid,
	output logic [1:0]          kind,
	output logic                status,
	output logic [IDX_W-1:0]    order_index,
	output logic [QTY_W-1:0]    fill_size,
	output logic [QTY_W-1:0]    order_filled,
	output logic [COST_W-1:0]   order_cost,
	output logic [QTY_W-1:0]    remaining_size,
	output logic                fully_taken,
	output logic                book_written,
	output logic [DQ_W-1:0]     deal_quantity_total,
	output logic [DC_W-1:0]     deal_cost_total,
	output logic                last
);

	// only slots reachable by the input field widths are stored
	localparam int EX_EFF = (NUM_EXCHANGES < 4) ? NUM_EXCHANGES : 4;
	localparam int SY_EFF = (NUM_SYMBOLS < 16) ? NUM_SYMBOLS : 16;
	localparam int SLOTS  = EX_EFF * SY_EFF;
	localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_WALK = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_SUM  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	quote_t            quote_q;
	logic              done_q;
	logic [SW-1:0]     slot_q;
	logic              accept;
	logic              in_range;
	logic [31:0]       slot_wide;
	logic [SW-1:0]     slot_in;

	// deal totals memory: quantity in the upper bits, cost below
	logic [DQ_W+DC_W-1:0] deal_mem [SLOTS];
	logic [SLOTS-1:0]     dvalid_q;
	logic [DQ_W+DC_W-1:0] rd_q;
	logic                 rdv_q;
	logic [DQ_W-1:0]      dq_q;
	logic [DC_W-1:0]      dc_q;
	logic                 pv_s1;
	logic [QTY_W-1:0]     deal_s1;
	logic [IDX_W-1:0]     idx_s1;
	order_t               ord_s1;
	logic [COST_W-1:0]    prod_cur;
	logic [DQ_W:0]        dq_sum;
	logic [DC_W:0]        dc_sum;

	order_t chain [MAX_ORDERS];
	order_t load_order;
	order_t head_next;
	order_t tail_in;
	fill_t  fill;
	logic   shift;
	logic   match_en;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign slot_wide = 32'(exchange_id) * SY_EFF + 32'(symbol_id);
	assign slot_in   = slot_wide[SW-1:0];
	assign in_range  = (32'(exchange_id) < NUM_EXCHANGES) && (32'(symbol_id) < NUM_SYMBOLS);
	assign shift     = (state_q == ST_WALK);
	assign match_en  = shift && (idx_q < count_q) && !done_q;

	always_comb begin
		load_order        = '0;
		load_order.side   = side;
		load_order.sym    = symbol_id;
		load_order.limit  = price_ticks;
		load_order.qty    = amount;
	end

	// cost stage: add the price times size of the fill registered from the match unit
	assign prod_cur = COST_W'(quote_q.price) * COST_W'(deal_s1);

	always_comb begin
		tail_in = ord_s1;
		if (pv_s1) begin
			tail_in.cost = ord_s1.cost + prod_cur;
		end
	end

	// ring of order cells plus the cost stage: each hands its order toward the
	// head every walk cycle, so a full turn moves every order through all of them
	for (genvar j = 0; j < MAX_ORDERS; j++) begin : g_cell
		order_t from_next;
		logic   load_en;
		if (j == MAX_ORDERS - 1) begin : g_tail
			assign from_next = tail_in;
		end else begin : g_mid
			assign from_next = chain[j+1];
		end
		assign load_en = accept && (command == CMD_LOAD) && (count_q == CNT_W'(j));
		qom_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.load_en    (load_en),
			.load_order (load_order),
			.from_next  (from_next),
			.order      (chain[j])
		);
	end

	qom_match u_match (
		.enable  (match_en),
		.head    (chain[0]),
		.quote   (quote_q),
		.updated (head_next),
		.fill    (fill)
	);

	// control: count loads and sequence one quote through read, full chain turn and summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			dvalid_q <= '0;
			pv_s1    <= 1'b0;
		end else begin
			pv_s1 <= match_en && fill.hit;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_LOAD) begin
							if (count_q < CNT_W'(MAX_ORDERS)) begin
								count_q <= count_q + 1'b1;
							end
						end else if (in_range) begin
							done_q  <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (match_en && fill.hit && fill.full) begin
						done_q <= 1'b1;
					end
					if (idx_q == CNT_W'(MAX_ORDERS)) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					dvalid_q[slot_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// quote registers, cost stage, totals memory and accumulators
	always_ff @(posedge clk) begin
		deal_s1 <= fill.deal;
		if (shift) begin
			ord_s1 <= head_next;
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (accept) begin
			quote_q.side  <= side;
			quote_q.sym   <= symbol_id;
			quote_q.price <= price_ticks;
			quote_q.rem   <= amount;
			slot_q        <= slot_in;
			rd_q          <= deal_mem[slot_in];
			rdv_q         <= dvalid_q[slot_in];
		end
		if (state_q == ST_INIT) begin
			dq_q <= rdv_q ? rd_q[DQ_W+DC_W-1:DC_W] : '0;
			dc_q <= rdv_q ? rd_q[DC_W-1:0] : '0;
		end else if (pv_s1) begin
			dq_q <= dq_sum[DQ_W] ? '1 : dq_sum[DQ_W-1:0];
			dc_q <= dc_sum[DC_W] ? '1 : dc_sum[DC_W-1:0];
		end
		if (match_en && fill.hit) begin
			quote_q.rem <= quote_q.rem - fill.deal;
		end
		if (state_q == ST_SUM) begin
			deal_mem[slot_q] <= {dq_q, dc_q};
		end
	end

	assign dq_sum = {1'b0, dq_q} + (DQ_W+1)'(deal_s1);
	assign dc_sum = {1'b0, dc_q} + (DC_W+1)'(prod_cur);

	// result register: one item per cycle, fields outside its kind held at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= (accept && (command == CMD_LOAD || !in_range))
			                || pv_s1 || (state_q == ST_SUM);
		end
	end

	always_ff @(posedge clk) begin
		kind                <= KIND_LOAD;
		status              <= 1'b0;
		order_index         <= '0;
		fill_size           <= '0;
		order_filled        <= '0;
		order_cost          <= '0;
		remaining_size      <= '0;
		fully_taken         <= 1'b0;
		book_written        <= 1'b0;
		deal_quantity_total <= '0;
		deal_cost_total     <= '0;
		last                <= 1'b1;
		if (accept && command == CMD_LOAD) begin
			if (count_q < CNT_W'(MAX_ORDERS)) begin
				order_index <= count_q[IDX_W-1:0];
			end else begin
				status <= 1'b1;
			end
		end else if (accept && !in_range) begin
			kind           <= KIND_SUM;
			remaining_size <= amount;
		end else if (state_q == ST_SUM) begin
			kind                <= KIND_SUM;
			remaining_size      <= quote_q.rem;
			fully_taken         <= done_q;
			book_written        <= !done_q;
			deal_quantity_total <= dq_q;
			deal_cost_total     <= dc_q;
		end else begin
			kind         <= KIND_FILL;
			order_index  <= idx_s1;
			fill_size    <= deal_s1;
			order_filled <= ord_s1.filled;
			order_cost   <= tail_in.cost;
			last         <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ORDERS))
		else $error("order count beyond capacity");
	a_fill_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_FILL) |-> !last)
		else $error("fill marked last");
	a_load_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_LOAD) |-> last)
		else $error("load acknowledge not last");
	a_no_fill_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && done_q && !pv_s1) |=> !(result_valid && kind == KIND_FILL))
		else $error("fill after quote fully taken");
`endif

endmodule

@@ verif/quote_order_matcher_core_tb.sv @@
// Self-checking testbench for the quote order matcher core.
module quote_order_matcher_core_tb
	import qom_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ORDER_SLOTS = 32;
	localparam int SYMBOLS     = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_TAIL   = 30;	// final items sent with no gaps
	localparam logic SIDE_SELL = 1'b1;
	localparam logic [DQ_W-1:0] DQ_TOP = '1;
	localparam logic [DC_W-1:0] DC_TOP = '1;

	typedef struct {
		logic               cmd;
		logic               side;
		logic [SYM_W-1:0]   sym;
		logic [EXCH_W-1:0]  exch;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   amt;
		bit                 drain;	// hold this item until every result is in
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               status;
		logic [IDX_W-1:0]   idx;
		logic [QTY_W-1:0]   fill;
		logic [QTY_W-1:0]   filled;
		logic [COST_W-1:0]  cost;
		logic [QTY_W-1:0]   rem;
		logic               taken;
		logic               booked;
		logic [DQ_W-1:0]    dq;
		logic [DC_W-1:0]    dc;
		logic               is_last;
	} res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                command = 1'b0;
	logic                side = 1'b0;
	logic [SYM_W-1:0]    symbol_id = '0;
	logic [EXCH_W-1:0]   exchange_id = '0;
	logic [PRICE_W-1:0]  price_ticks = '0;
	logic [QTY_W-1:0]    amount = '0;
	logic                result_valid;
	logic [1:0]          kind;
	logic                status;
	logic [IDX_W-1:0]    order_index;
	logic [QTY_W-1:0]    fill_size;
	logic [QTY_W-1:0]    order_filled;
	logic [COST_W-1:0]   order_cost;
	logic [QTY_W-1:0]    remaining_size;
	logic                fully_taken;
	logic                book_written;
	logic [DQ_W-1:0]     deal_quantity_total;
	logic [DC_W-1:0]     deal_cost_total;
	logic                last;

	quote_order_matcher_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .side(side), .symbol_id(symbol_id),
		.exchange_id(exchange_id), .price_ticks(price_ticks), .amount(amount),
		.result_valid(result_valid), .kind(kind), .status(status),
		.order_index(order_index), .fill_size(fill_size),
		.order_filled(order_filled), .order_cost(order_cost),
		.remaining_size(remaining_size), .fully_taken(fully_taken),
		.book_written(book_written), .deal_quantity_total(deal_quantity_total),
		.deal_cost_total(deal_cost_total), .last(last)
	);

	// Shadow of the order table and deal totals
	int                  book_count;
	logic                ord_side   [ORDER_SLOTS];
	logic [SYM_W-1:0]    ord_sym    [ORDER_SLOTS];
	logic [PRICE_W-1:0]  ord_limit  [ORDER_SLOTS];
	logic [QTY_W-1:0]    ord_qty    [ORDER_SLOTS];
	logic [QTY_W-1:0]    ord_filled [ORDER_SLOTS];
	logic [COST_W-1:0]   ord_cost   [ORDER_SLOTS];
	logic [DQ_W-1:0]     dealt_qty  [64];
	logic [DC_W-1:0]     dealt_cost [64];

	item_t pending_items[$];
	res_t  expected_results[$];
	item_t cur_item;
	int    gap_left;
	int    sent_count;
	int    total_items;
	int    errors;
	int    cycles;
	int    n_loads, n_full_drops, n_quotes, n_fills, n_swept;

	initial begin
		forever #4 clk = ~clk;
	end

	// Work out every result an accepted item causes and queue it in order.
	task automatic match_item(input item_t it);
		int i;
		int slot;
		logic [QTY_W-1:0] rem;
		logic [QTY_W-1:0] open;
		logic [QTY_W-1:0] deal;
		logic [63:0] prod;
		logic [63:0] sum;
		bit taken;
		bit price_ok;
		res_t r;
		r = '0;
		r.is_last = 1'b1;
		if (it.cmd == CMD_LOAD) begin
			r.kind = KIND_LOAD;
			if (book_count >= ORDER_SLOTS) begin
				r.status = 1'b1;
				n_full_drops++;
			end else begin
				ord_side[book_count]   = it.side;
				ord_sym[book_count]    = it.sym;
				ord_limit[book_count]  = it.price;
				ord_qty[book_count]    = it.amt;
				ord_filled[book_count] = '0;
				ord_cost[book_count]   = '0;
				r.idx = book_count[IDX_W-1:0];
				book_count++;
				n_loads++;
			end
			expected_results = {expected_results, r};
			return;
		end
		n_quotes++;
		slot = it.exch * SYMBOLS + it.sym;
		rem = it.amt;
		taken = 0;
		for (i = 0; i < book_count; i++) begin
			if (ord_sym[i] != it.sym || ord_side[i] == it.side)
				continue;
			// a bid lifts sells at or below it, an ask hits buys at or above it
			price_ok = (it.side == SIDE_BID) ? (it.price >= ord_limit[i])
				: (it.price <= ord_limit[i]);
			if (!price_ok || ord_filled[i] >= ord_qty[i])
				continue;
			open = ord_qty[i] - ord_filled[i];
			if (rem <= open) begin
				deal = rem;
				taken = 1;
			end else begin
				deal = open;
			end
			rem -= deal;
			prod = 64'(it.price) * 64'(deal);
			ord_filled[i] += deal;
			ord_cost[i] = ord_cost[i] + prod[COST_W-1:0];
			sum = 64'(dealt_qty[slot]) + 64'(deal);
			dealt_qty[slot] = (sum > 64'(DQ_TOP)) ? DQ_TOP : sum[DQ_W-1:0];
			sum = 64'(dealt_cost[slot]) + prod;
			dealt_cost[slot] = (sum > 64'(DC_TOP)) ? DC_TOP : sum[DC_W-1:0];
			r = '0;
			r.kind = KIND_FILL;
			r.idx = i[IDX_W-1:0];
			r.fill = deal;
			r.filled = ord_filled[i];
			r.cost = ord_cost[i];
			expected_results = {expected_results, r};
			n_fills++;
			if (taken)
				break;
		end
		if (taken)
			n_swept++;
		r = '0;
		r.kind = KIND_SUM;
		r.rem = rem;
		r.taken = taken;
		r.booked = !taken;
		r.dq = dealt_qty[slot];
		r.dc = dealt_cost[slot];
		r.is_last = 1'b1;
		expected_results = {expected_results, r};
	endtask

	// Driver: predict at acceptance, then hold, idle or present the next item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				match_item(cur_item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0 &&
					!(pending_items[0].drain && expected_results.size() != 0)) begin
					cur_item = pending_items.pop_front();
					command     <= cur_item.cmd;
					side        <= cur_item.side;
					symbol_id   <= cur_item.sym;
					exchange_id <= cur_item.exch;
					price_ticks <= cur_item.price;
					amount      <= cur_item.amt;
					start       <= 1'b1;
					sent_count++;
					// idle in short bursts, but keep the tail of the run dense
					if (sent_count < total_items - CALM_TAIL && $urandom_range(0, 2) == 0)
						gap_left = $urandom_range(1, 4);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name,
				want, got);
			errors++;
		end
	endtask

	// Monitor: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, kind %0d index %0d", $realtime, kind,
					order_index);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("status", want.status, status);
				check_field("order_index", want.idx, order_index);
				check_field("fill_size", want.fill, fill_size);
				check_field("order_filled", want.filled, order_filled);
				check_field("order_cost", want.cost, order_cost);
				check_field("remaining_size", want.rem, remaining_size);
				check_field("fully_taken", want.taken, fully_taken);
				check_field("book_written", want.booked, book_written);
				check_field("deal_quantity_total", want.dq, deal_quantity_total);
				check_field("deal_cost_total", want.dc, deal_cost_total);
				check_field("last", want.is_last, last);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL quote_order_matcher_core");
			$finish;
		end
	end

	function automatic item_t mk(input logic cmd, input logic sd, input int sym,
		input int exch, input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] amt);
		item_t it;
		it.cmd = cmd;
		it.side = sd;
		it.sym = sym[SYM_W-1:0];
		it.exch = exch[EXCH_W-1:0];
		it.price = price;
		it.amt = amt;
		it.drain = 0;
		return it;
	endfunction

	// Random item: few symbols and prices near one level so orders really cross.
	function automatic item_t rand_item();
		item_t it;
		it.cmd = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_QUOTE;
		it.side = 1'($urandom_range(0, 1));
		it.sym = SYM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
			: $urandom_range(4, 6));
		it.exch = EXCH_W'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: it.price = '1;
			1: it.price = '0;
			2: it.price = PRICE_W'($urandom());
			default: it.price = PRICE_W'(1000 + $urandom_range(0, 100) - 50);
		endcase
		case ($urandom_range(0, 9))
			0: it.amt = '0;
			1: it.amt = QTY_W'($urandom());
			default: it.amt = QTY_W'($urandom_range(1, 400));
		endcase
		it.drain = 0;
		return it;
	endfunction

	initial begin
		int k;
		item_t it;
		errors = 0;
		cycles = 0;
		sent_count = 0;
		book_count = 0;
		n_loads = 0;
		n_full_drops = 0;
		n_quotes = 0;
		n_fills = 0;
		n_swept = 0;
		for (k = 0; k < 64; k++) begin
			dealt_qty[k] = '0;
			dealt_cost[k] = '0;
		end

		// Zero-quantity order that is never open, then a real buy at 100.
		pending_items = {pending_items, mk(CMD_LOAD, SIDE_BID, 0, 0, '1, '0)};
		pending_items = {pending_items, mk(CMD_LOAD, SIDE_BID, 0, 0, 24'd100, 20'd5)};
		// Zero-size ask meets the open buy: one fill of size zero, wholly taken.
		pending_items = {pending_items, mk(CMD_QUOTE, SIDE_SELL, 0, 0, 24'd100, '0)};
		// Ask above every buy limit: no fill, book entry written.
		pending_items = {pending_items, mk(CMD_QUOTE, SIDE_SELL, 0, 1, '1, '1)};
		// Ask at price zero sweeps the buy and leaves size over.
		pending_items = {pending_items, mk(CMD_QUOTE, SIDE_SELL, 0, 2, '0, 20'd8)};
		// Bid with nothing to meet.
		pending_items = {pending_items, mk(CMD_QUOTE, SIDE_BID, 0, 0, 24'd50, 20'd3)};
		// Saturate a deal quantity total: many full-size sells swept by full-size bids.
		for (k = 0; k < 17; k++)
			pending_items = {pending_items, mk(CMD_LOAD, SIDE_SELL, 15, 0, '0, '1)};
		for (k = 0; k < 17; k++)
			pending_items = {pending_items, mk(CMD_QUOTE, SIDE_BID, 15, 3, '1, '1)};

		for (k = 0; k < 96; k++) begin
			it = rand_item();
			if (k == 75)
				it.drain = 1;
			pending_items = {pending_items, it};
		end
		// Loads with the table certainly full.
		for (k = 0; k < 14; k++)
			pending_items = {pending_items, mk(CMD_LOAD, k[0], k, k,
				PRICE_W'($urandom()), QTY_W'($urandom()))};
		total_items = pending_items.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d stored loads, %0d dropped on a full table, %0d quotes",
			n_loads, n_full_drops, n_quotes);
		$display("with %0d fills and %0d quotes wholly taken", n_fills, n_swept);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS quote_order_matcher_core");
		end else begin
			$display("FAIL quote_order_matcher_core");
		end
		$finish;
	end

endmodule
